// ===== hdl/slpm_pkg.sv =====
// Shared types, constants and helpers for the sprite line unit.
package slpm_pkg;

	localparam int unsigned SPRITE_HEIGHT = 8;
	localparam int unsigned ROW_W = $clog2(SPRITE_HEIGHT);
	localparam int unsigned SHIFT_W = 4;

	localparam logic [13:0] BACKDROP_ADDR = 14'h3F00;
	localparam logic [13:0] SPRITE_PAL_ADDR = 14'h3F10;
	localparam logic [12:0] HIGH_TABLE_BASE = 13'h1000;
	localparam logic [SHIFT_W-1:0] SHIFT_LOAD = SHIFT_W'(SPRITE_HEIGHT);

	localparam int unsigned ATTR_FLIP_Y = 7;
	localparam int unsigned ATTR_FLIP_X = 6;
	localparam int unsigned ATTR_BEHIND = 5;

	localparam int unsigned IN_DATA_W = 72;
	localparam int unsigned OUT_DATA_W = 40;

	typedef enum logic [2:0] {
		OP_START_LINE = 3'd0,
		OP_OFFER      = 3'd1,
		OP_PATTERN    = 3'd2,
		OP_DOT        = 3'd3,
		OP_CLEAR_HIT  = 3'd4
	} slpm_op_t;

	// slot command broadcast from control to every cell
	typedef struct packed {
		logic       clear;
		logic       load_oam;
		logic       load_pat;
		logic       dot;
		logic [7:0] x;
		logic [1:0] palette;
		logic       behind;
		logic       is_zero;
		logic [7:0] plane_lo;
		logic [7:0] plane_hi;
	} slpm_cmd_t;

	// priority result handed down the chain
	typedef struct packed {
		logic       found;
		logic [1:0] color;
		logic [1:0] palette;
		logic       behind;
		logic       is_zero;
	} slpm_pix_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[b] = v[7-b];
		end
		return r;
	endfunction

endpackage

// ===== hdl/sprite_line_unit_pixel_priority_mux_top.sv =====
// Sprite line unit top: item decode, slot control, cell chain and output register.
// Each result is registered and shows on m_tvalid in the cycle after its input transaction.
// Throughput: one input transaction per cycle while m_tready is high; every item gives one result.
// The priority search ripples combinationally through the row of slot cells.
// Reset (arst_n low, asynchronous): all slots, slot count, pending entry, hit flag and
// table select clear; no result is pending.
module sprite_line_unit_pixel_priority_mux_top import slpm_pkg::*; #(
	parameter int unsigned SPRITE_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// scanline, oam_y, oam_tile, oam_attr, oam_x, oam_number, pattern_low,
	// pattern_high, bg_pixel, bg_palette (low to high), zero padded
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sprite_accepted, pattern_address, palette_address, zero_hit,
	// slots_used (low to high), zero padded
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	localparam int unsigned TW = $clog2(SPRITE_SLOTS + 1);

	logic [8:0] scanline;
	logic [7:0] oam_y;
	logic [7:0] oam_tile;
	logic [7:0] oam_attr;
	logic [7:0] oam_x;
	logic [5:0] oam_number;
	logic [7:0] pattern_low;
	logic [7:0] pattern_high;
	logic [1:0] bg_pixel;
	logic [1:0] bg_palette;

	assign scanline = s_tdata[8:0];
	assign oam_y = s_tdata[16:9];
	assign oam_tile = s_tdata[24:17];
	assign oam_attr = s_tdata[32:25];
	assign oam_x = s_tdata[40:33];
	assign oam_number = s_tdata[46:41];
	assign pattern_low = s_tdata[54:47];
	assign pattern_high = s_tdata[62:55];
	assign bg_pixel = s_tdata[64:63];
	assign bg_palette = s_tdata[66:65];

	logic          table_high_q;
	logic [TW-1:0] slot_total_q;
	logic          pending_valid_q;
	logic          pending_flip_x_q;
	logic          hit_q;
	logic          m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic       accept;
	logic [7:0] top;
	logic       covers;
	logic       has_free;
	logic [ROW_W-1:0] row;
	logic       offer_ok;
	logic       pat_ok;
	slpm_cmd_t  cmd;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	assign top = oam_y + 8'd1;
	assign covers = (scanline >= {1'b0, top})
		&& ({1'b0, scanline} < ({2'b00, top} + 10'(SPRITE_HEIGHT)));
	assign has_free = slot_total_q < TW'(SPRITE_SLOTS);
	assign row = oam_attr[ATTR_FLIP_Y] ? ~(scanline[ROW_W-1:0] - top[ROW_W-1:0])
		: (scanline[ROW_W-1:0] - top[ROW_W-1:0]);
	assign offer_ok = covers && has_free;
	assign pat_ok = pending_valid_q && has_free;

	always_comb begin
		cmd = '0;
		cmd.x = oam_x;
		cmd.palette = oam_attr[1:0];
		cmd.behind = oam_attr[ATTR_BEHIND];
		cmd.is_zero = (oam_number == 6'd0);
		cmd.plane_lo = pending_flip_x_q ? reverse8(pattern_low) : pattern_low;
		cmd.plane_hi = pending_flip_x_q ? reverse8(pattern_high) : pattern_high;
		cmd.clear = accept && (s_tuser == OP_START_LINE);
		cmd.load_oam = accept && (s_tuser == OP_OFFER) && offer_ok;
		cmd.load_pat = accept && (s_tuser == OP_PATTERN) && pat_ok;
		cmd.dot = accept && (s_tuser == OP_DOT);
	end

	slpm_pix_t pix [0:SPRITE_SLOTS];
	assign pix[0] = '0;

	for (genvar i = 0; i < SPRITE_SLOTS; i++) begin : g_cell
		slpm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.sel    (slot_total_q == TW'(i)),
			.active (TW'(i) < slot_total_q),
			.pix_in (pix[i]),
			.pix_out(pix[i+1])
		);
	end

	slpm_pix_t win;
	assign win = pix[SPRITE_SLOTS];

	logic          acc_n;
	logic [12:0]   pat_addr_n;
	logic [13:0]   pal_addr_n;
	logic          hit_n;
	logic [TW-1:0] total_n;
	logic          pending_n;
	logic [3:0]    used_n;

	always_comb begin
		acc_n = 1'b0;
		pat_addr_n = '0;
		pal_addr_n = BACKDROP_ADDR;
		hit_n = hit_q;
		total_n = slot_total_q;
		pending_n = pending_valid_q;
		unique case (s_tuser)
			OP_START_LINE: begin
				total_n = '0;
				pending_n = 1'b0;
			end
			OP_OFFER: begin
				if (offer_ok) begin
					acc_n = 1'b1;
					pat_addr_n = (table_high_q ? HIGH_TABLE_BASE : 13'd0)
						+ 13'({oam_tile, 4'b0000}) + 13'(row);
					pending_n = 1'b1;
				end
			end
			OP_PATTERN: begin
				if (pat_ok) begin
					total_n = slot_total_q + TW'(1);
				end
				pending_n = 1'b0;
			end
			OP_DOT: begin
				if (win.found && ((bg_pixel == 2'd0) || !win.behind)) begin
					pal_addr_n = SPRITE_PAL_ADDR | 14'({win.palette, win.color});
				end else if (bg_pixel != 2'd0) begin
					pal_addr_n = BACKDROP_ADDR | 14'({bg_palette, bg_pixel});
				end
				if (win.found && win.is_zero && (bg_pixel != 2'd0)) begin
					hit_n = 1'b1;
				end
			end
			OP_CLEAR_HIT: begin
				hit_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign used_n = 4'(total_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_high_q <= 1'b0;
			slot_total_q <= '0;
			pending_valid_q <= 1'b0;
			pending_flip_x_q <= 1'b0;
			hit_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_high_q <= cfg_data;
			end
			if (accept) begin
				slot_total_q <= total_n;
				pending_valid_q <= pending_n;
				hit_q <= hit_n;
				if (cmd.load_oam) begin
					pending_flip_x_q <= oam_attr[ATTR_FLIP_X];
				end else if (cmd.clear) begin
					pending_flip_x_q <= 1'b0;
				end
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {7'd0, used_n, hit_n, pal_addr_n, pat_addr_n, acc_n};
		end
	end

`ifndef NO_ASSERTIONS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_total_q <= TW'(SPRITE_SLOTS))
		else $error("slot count beyond slot capacity");

	a_pending_room: assert property (@(posedge clk) disable iff (!arst_n)
		pending_valid_q |-> (slot_total_q < TW'(SPRITE_SLOTS)))
		else $error("pending sprite with no free slot");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == OP_START_LINE)) |=> (slot_total_q == '0) && !pending_valid_q)
		else $error("start_line did not clear the slots");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid_q)
		else $error("accepted transaction produced no result");
`endif

endmodule

// ===== hdl/slpm_cell.sv =====
// One sprite slot: holds shifters and x counter, joins the pixel priority chain.
module slpm_cell import slpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  slpm_cmd_t cmd,
	input  logic      sel,
	input  logic      active,
	input  slpm_pix_t pix_in,
	output slpm_pix_t pix_out
);

	logic [7:0]         x_q;
	logic [7:0]         plo_q;
	logic [7:0]         phi_q;
	logic [SHIFT_W-1:0] shifts_q;
	logic [1:0]         pal_q;
	logic               behind_q;
	logic               zero_q;

	logic       shifting;
	logic [1:0] color;
	logic       opaque;

	assign shifting = (x_q == 8'd0) && (shifts_q != '0);
	assign color = {phi_q[7], plo_q[7]};
	assign opaque = active && shifting && (color != 2'b00);

	always_comb begin
		pix_out = pix_in;
		if (!pix_in.found && opaque) begin
			pix_out.found = 1'b1;
			pix_out.color = color;
			pix_out.palette = pal_q;
			pix_out.behind = behind_q;
			pix_out.is_zero = zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			shifts_q <= '0;
			pal_q <= '0;
			behind_q <= 1'b0;
			zero_q <= 1'b0;
		end else if (cmd.clear) begin
			x_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			shifts_q <= '0;
			pal_q <= '0;
			behind_q <= 1'b0;
			zero_q <= 1'b0;
		end else if (cmd.load_oam && sel) begin
			x_q <= cmd.x;
			pal_q <= cmd.palette;
			behind_q <= cmd.behind;
			zero_q <= cmd.is_zero;
		end else if (cmd.load_pat && sel) begin
			plo_q <= cmd.plane_lo;
			phi_q <= cmd.plane_hi;
			shifts_q <= SHIFT_LOAD;
		end else if (cmd.dot && active) begin
			if (shifting) begin
				plo_q <= {plo_q[6:0], 1'b0};
				phi_q <= {phi_q[6:0], 1'b0};
				shifts_q <= shifts_q - SHIFT_W'(1);
			end else begin
				x_q <= x_q - 8'd1;
			end
		end
	end

endmodule
